[rtl/afs_pkg.sv]
// Package with shared constants and types for the animation frame scheduler.
`default_nettype none
package afs_pkg;
  localparam int MAX_FRAMES = 256;
  localparam int SLOT_W = $clog2(MAX_FRAMES);
  localparam int CNT_W = SLOT_W + 1;
  localparam int DUR_W = 16;
  localparam int TOT_W = 24;
  localparam int TIME_W = 32;
  localparam int QCNT_W = $clog2(TIME_W);

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic REG_FRAME_COUNT = 1'b0;
  localparam logic REG_LOOP_LIMIT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_DIV,
    ST_WALK,
    ST_SUM,
    ST_RESULT
  } state_t;
endpackage
`default_nettype wire

[rtl/animation_frame_scheduler_core.sv]
// Animation frame scheduler: duration table, loop total and frame lookup for a time.
//
// Requests enter on req_valid/req_stall. mode 0 writes one frame duration into the
// table (negative values stored as zero) and gives no result. mode 1 queries the
// frame due at anim_time and gives one result on rsp_valid/rsp_stall.
// A write request reads the old entry while taken in idle; the write state then stores
// the duration and patches the loop total when the slot is within the frames in use.
// A query is taken in idle and runs the bit-serial divider over the time, then a table
// walk of one entry per cycle through the duration memory, then moves the result into
// the output register. A query that reaches the loop limit skips the walk.
// Queries with fewer than two frames or a zero loop total skip the divider and the walk.
// Writing a nonzero frame count while idle starts a sum over the table, one entry per cycle
// through the memory read port unless a config write restarts it; requests stall meanwhile.
// One request is worked on at a time; the next is taken while a result waits in
// the output register. When the receiver stalls, a finished query waits until the
// output register frees. Reset clears the frame count, loop limit, loop total and the
// repeat tracking; the duration table is undefined until written.
`default_nettype none
module animation_frame_scheduler_core (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // Configuration port
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [2:0]                   paddr,
  input  wire logic [31:0]                  pwdata,
  output logic      [31:0]                  prdata,
  output logic                              pready,
  // Request channel
  input  wire logic                         req_valid,
  output logic                              req_stall,
  input  wire logic                         mode,
  input  wire logic [afs_pkg::SLOT_W-1:0]   frame_slot,
  input  wire logic signed [afs_pkg::DUR_W-1:0] duration,
  input  wire logic [afs_pkg::TIME_W-1:0]   anim_time,
  // Result channel
  output logic                              rsp_valid,
  input  wire logic                         rsp_stall,
  output logic [afs_pkg::SLOT_W-1:0]        frame_index,
  output logic                              finished,
  output logic                              repeated,
  output logic                              next_valid,
  output logic [afs_pkg::TIME_W-1:0]        next_time
);

  afs_pkg::state_t state, state_next;

  logic [afs_pkg::CNT_W-1:0]  num_frames;
  logic [15:0]                loop_limit;
  logic [afs_pkg::TOT_W-1:0]  loop_total;
  logic                       shown_valid;
  logic [afs_pkg::SLOT_W-1:0] last_shown;

  logic [afs_pkg::DUR_W-1:0]  dur_mem [afs_pkg::MAX_FRAMES];
  logic [afs_pkg::SLOT_W-1:0] mem_raddr;
  logic [afs_pkg::DUR_W-1:0]  mem_rdata;
  logic                       mem_we;

  logic [afs_pkg::SLOT_W-1:0] wr_slot;
  logic [afs_pkg::DUR_W-1:0]  wr_dur;
  logic [afs_pkg::TIME_W-1:0] q_time;
  logic [afs_pkg::TIME_W-1:0] dvd;
  logic [afs_pkg::TIME_W-1:0] quo;
  logic [afs_pkg::TOT_W:0]    rem;
  logic [afs_pkg::QCNT_W-1:0] div_cnt;
  logic [afs_pkg::CNT_W-1:0]  iss;
  logic                       rdv;
  logic [afs_pkg::SLOT_W-1:0] ridx;
  logic [afs_pkg::TOT_W-1:0]  acc;

  logic [afs_pkg::SLOT_W-1:0] res_frame;
  logic                       res_fin, res_rep, res_nvalid;
  logic [afs_pkg::TIME_W-1:0] res_ntime;

  logic [afs_pkg::CNT_W-1:0]  n_use;
  logic                       req_acc, cfg_wr, cfg_idx;
  logic [afs_pkg::CNT_W-1:0]  cfg_count;
  logic [afs_pkg::CNT_W-1:0]  cfg_n_use;
  logic [afs_pkg::TOT_W:0]    rem_sh;
  logic                       rem_ge;
  logic [afs_pkg::TOT_W-1:0]  acc_new;
  logic                       walk_last, walk_hit, rsp_free, div_done, lim_hit;
  logic [afs_pkg::TIME_W:0]   ntime_full;
  logic [afs_pkg::DUR_W-1:0]  clamp_dur;
  logic                       slot_in_use, trivial_q;

  // Frames in use, saturated at the table depth.
  assign n_use = (num_frames > afs_pkg::CNT_W'(afs_pkg::MAX_FRAMES))
               ? afs_pkg::CNT_W'(afs_pkg::MAX_FRAMES) : num_frames;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[2];
  assign cfg_count = pwdata[afs_pkg::CNT_W-1:0];
  assign cfg_n_use = (cfg_count > afs_pkg::CNT_W'(afs_pkg::MAX_FRAMES))
                   ? afs_pkg::CNT_W'(afs_pkg::MAX_FRAMES) : cfg_count;

  // Register readback.
  always_comb begin
    prdata = '0;
    case (cfg_idx)
      afs_pkg::REG_FRAME_COUNT: prdata = {{(32 - afs_pkg::CNT_W){1'b0}}, num_frames};
      afs_pkg::REG_LOOP_LIMIT:  prdata = {16'd0, loop_limit};
      default:                  prdata = '0;
    endcase
  end

  assign req_acc = req_valid && !req_stall;
  assign clamp_dur = duration[afs_pkg::DUR_W-1] ? '0 : duration;
  assign slot_in_use = {1'b0, wr_slot} < n_use;
  assign trivial_q = (n_use < afs_pkg::CNT_W'(2)) || (loop_total == '0);

  // One restoring divider step per cycle.
  assign rem_sh = {rem[afs_pkg::TOT_W-1:0], dvd[afs_pkg::TIME_W-1]};
  assign rem_ge = rem_sh >= {1'b0, loop_total};
  assign div_done = div_cnt == afs_pkg::QCNT_W'(afs_pkg::TIME_W - 1);
  assign lim_hit = (loop_limit != '0) &&
                   ({quo[afs_pkg::TIME_W-2:0], rem_ge} >= {16'd0, loop_limit});

  // Table walk: accumulated duration and stop conditions.
  assign acc_new = acc + afs_pkg::TOT_W'(mem_rdata);
  assign walk_last = {1'b0, ridx} == (n_use - afs_pkg::CNT_W'(1));
  assign walk_hit = acc_new > rem[afs_pkg::TOT_W-1:0];
  assign ntime_full = {1'b0, q_time} - afs_pkg::TIME_W'(rem[afs_pkg::TOT_W-1:0])
                    + afs_pkg::TIME_W'(acc_new);
  assign rsp_free = !rsp_valid || !rsp_stall;

  // Next state, request stall and memory control.
  always_comb begin
    state_next = state;
    req_stall = 1'b1;
    mem_raddr = iss[afs_pkg::SLOT_W-1:0];
    mem_we = 1'b0;
    case (state)
      afs_pkg::ST_IDLE: begin
        req_stall = cfg_wr;
        mem_raddr = frame_slot;
        if (cfg_wr) begin
          if (cfg_idx == afs_pkg::REG_FRAME_COUNT && cfg_n_use != '0) begin
            state_next = afs_pkg::ST_SUM;
          end
        end else if (req_valid) begin
          if (mode == afs_pkg::MODE_WRITE) begin
            state_next = afs_pkg::ST_WRITE;
          end else if (trivial_q) begin
            state_next = afs_pkg::ST_RESULT;
          end else begin
            state_next = afs_pkg::ST_DIV;
          end
        end
      end
      afs_pkg::ST_WRITE: begin
        mem_we = 1'b1;
        state_next = afs_pkg::ST_IDLE;
      end
      afs_pkg::ST_DIV: begin
        if (div_done) begin
          state_next = lim_hit ? afs_pkg::ST_RESULT : afs_pkg::ST_WALK;
        end
      end
      afs_pkg::ST_WALK: begin
        if (rdv && (walk_hit || walk_last)) begin
          state_next = afs_pkg::ST_RESULT;
        end
      end
      afs_pkg::ST_SUM: begin
        if (cfg_wr && cfg_idx == afs_pkg::REG_FRAME_COUNT && cfg_n_use == '0) begin
          state_next = afs_pkg::ST_IDLE;
        end else if (!cfg_wr && rdv && walk_last) begin
          state_next = afs_pkg::ST_IDLE;
        end
      end
      afs_pkg::ST_RESULT: begin
        if (rsp_free) begin
          state_next = afs_pkg::ST_IDLE;
        end
      end
      default: state_next = afs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= afs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Duration memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      dur_mem[wr_slot] <= wr_dur;
    end
    mem_rdata <= dur_mem[mem_raddr];
  end

  // Configuration registers, loop total and repeat tracking.
  always_ff @(posedge clk) begin
    if (rst) begin
      num_frames <= '0;
      loop_limit <= '0;
      loop_total <= '0;
      shown_valid <= 1'b0;
      last_shown <= '0;
    end else begin
      if (cfg_wr) begin
        case (cfg_idx)
          afs_pkg::REG_FRAME_COUNT: begin
            num_frames <= cfg_count;
            if (cfg_n_use == '0) begin
              loop_total <= '0;
            end
          end
          afs_pkg::REG_LOOP_LIMIT: loop_limit <= pwdata[15:0];
          default: ;
        endcase
      end
      if (state == afs_pkg::ST_WRITE && slot_in_use) begin
        loop_total <= loop_total - afs_pkg::TOT_W'(mem_rdata) + afs_pkg::TOT_W'(wr_dur);
      end
      if (state == afs_pkg::ST_SUM && !cfg_wr && rdv && walk_last) begin
        loop_total <= acc_new;
      end
      if (state == afs_pkg::ST_DIV && div_done && lim_hit) begin
        shown_valid <= 1'b1;
        last_shown <= afs_pkg::SLOT_W'(n_use - afs_pkg::CNT_W'(1));
      end
      if (state == afs_pkg::ST_WALK && rdv && (walk_hit || walk_last)) begin
        shown_valid <= 1'b1;
        last_shown <= ridx;
      end
    end
  end

  // Datapath: request capture, divider and walk engine.
  always_ff @(posedge clk) begin
    rdv <= 1'b0;
    ridx <= iss[afs_pkg::SLOT_W-1:0];
    case (state)
      afs_pkg::ST_IDLE: begin
        wr_slot <= frame_slot;
        wr_dur <= clamp_dur;
        q_time <= anim_time;
        dvd <= anim_time;
        quo <= '0;
        rem <= '0;
        div_cnt <= '0;
        iss <= '0;
        acc <= '0;
        res_frame <= '0;
        res_fin <= 1'b0;
        res_rep <= 1'b0;
        res_nvalid <= 1'b0;
        res_ntime <= '0;
      end
      afs_pkg::ST_DIV: begin
        dvd <= {dvd[afs_pkg::TIME_W-2:0], 1'b0};
        quo <= {quo[afs_pkg::TIME_W-2:0], rem_ge};
        rem <= rem_ge ? (rem_sh - {1'b0, loop_total}) : rem_sh;
        div_cnt <= div_cnt + afs_pkg::QCNT_W'(1);
        if (div_done && lim_hit) begin
          res_frame <= afs_pkg::SLOT_W'(n_use - afs_pkg::CNT_W'(1));
          res_fin <= 1'b1;
        end
      end
      afs_pkg::ST_WALK, afs_pkg::ST_SUM: begin
        if (state == afs_pkg::ST_SUM && cfg_wr) begin
          iss <= '0;
          acc <= '0;
        end else begin
          if (iss < n_use) begin
            iss <= iss + afs_pkg::CNT_W'(1);
            rdv <= 1'b1;
          end
          if (rdv) begin
            acc <= acc_new;
          end
        end
        if (state == afs_pkg::ST_WALK && rdv && (walk_hit || walk_last)) begin
          res_frame <= ridx;
          res_rep <= (ridx == '0) && shown_valid && (last_shown != '0);
          res_nvalid <= 1'b1;
          res_ntime <= ntime_full[afs_pkg::TIME_W] ? '1 : ntime_full[afs_pkg::TIME_W-1:0];
        end
      end
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == afs_pkg::ST_RESULT && rsp_free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == afs_pkg::ST_RESULT && rsp_free) begin
      frame_index <= res_frame;
      finished <= res_fin;
      repeated <= res_rep;
      next_valid <= res_nvalid;
      next_time <= res_ntime;
    end
  end

  // A finished result never carries a next change time.
  a_fin_no_next: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(finished && next_valid))
    else $error("finished result with next time");

  // A repeat is only flagged on frame zero.
  a_rep_frame0: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && repeated |-> frame_index == '0)
    else $error("repeat flagged on nonzero frame");

  // A write request patches the table in the write state and then returns to idle.
  a_write_seq: assert property (@(posedge clk) disable iff (rst)
    req_acc && mode == afs_pkg::MODE_WRITE |=>
      state == afs_pkg::ST_WRITE ##1 state == afs_pkg::ST_IDLE)
    else $error("write request sequence broken");

  // The walk never returns data beyond the frames in use.
  a_walk_range: assert property (@(posedge clk) disable iff (rst)
    state == afs_pkg::ST_WALK && rdv |-> {1'b0, ridx} < n_use)
    else $error("walk read beyond frames in use");

endmodule
`default_nettype wire
